// ===== sv/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the i2c master transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none
package i2cm_pkg;
  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;

  localparam logic [1:0] OP_WR     = 2'd0;
  localparam logic [1:0] OP_RD     = 2'd1;
  localparam logic [1:0] OP_REG_WR = 2'd2;
  localparam logic [1:0] OP_REG_RD = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DEV_NAK  = 3'd1;
  localparam logic [2:0] ST_REG_NAK  = 3'd2;
  localparam logic [2:0] ST_DATA_NAK = 3'd3;
  localparam logic [2:0] ST_ZERO_LEN = 3'd4;

  localparam logic [15:0] QUARTER_RESET = 16'd125;

  // one input item as carried through the queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  op;
    logic [7:0]  target_addr;
    logic [7:0]  reg_addr;
    logic [15:0] length;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       byte_request;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic [2:0] status;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Input stage: takes items, cleans unused kind codes, two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module i2cm_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  i2cm_pkg::item_t in_item_i,
  output logic            q_valid_o,
  input  wire             q_pop_i,
  output i2cm_pkg::item_t q_item_o
);
  i2cm_pkg::item_t mem_q [2];
  logic rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  i2cm_pkg::item_t cls;

  // classify: kind 3 becomes idle
  always_comb begin
    cls = in_item_i;
    if (in_item_i.kind != i2cm_pkg::KIND_START && in_item_i.kind != i2cm_pkg::KIND_BYTE)
      cls.kind = i2cm_pkg::KIND_IDLE;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_pop_i;
  assign q_item_o = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> cnt_q != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push lost");
endmodule
`default_nettype wire

// ===== sv/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: runs one step per item, output register plus skid slot.
// ----------------------------------------------------------------------------
`default_nettype none
module i2cm_back #(
  parameter int LENGTH_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire [15:0]        quarter_i,
  input  wire               q_valid_i,
  output logic              q_pop_o,
  input  i2cm_pkg::item_t   q_item_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output i2cm_pkg::result_t out_res_o
);
  typedef enum logic [4:0] {
    PH_IDLE, PH_START_HI, PH_START_SDA, PH_START_LOW, PH_TX_SETUP, PH_TX_HIGH,
    PH_TX_LOW, PH_ACK_REL, PH_ACK_HIGH, PH_WAIT_BYTE, PH_RX_LOW, PH_RX_HIGH,
    PH_M_LOW, PH_M_HIGH, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_REL
  } phase_e;
  typedef enum logic [2:0] {
    SG_DEV, SG_REG, SG_DATA_TX, SG_REREAD, SG_DATA_RX
  } stage_e;

  phase_e phase_q, phase_d;
  stage_e stage_q, stage_d;
  logic [15:0] div_q, div_d;
  logic [7:0] shift_q, shift_d, dev_q, dev_d, reg_q, reg_d;
  logic [2:0] bit_q, bit_d, pend_q, pend_d;
  logic [LENGTH_BITS-1:0] left_q, left_d, left_dec, len_in;
  logic [1:0] op_q, op_d;
  logic scl_q, scl_d, sda_q, sda_d;
  logic tick;
  logic [15:0] qp;
  logic [16:0] div_inc;
  i2cm_pkg::result_t res;
  i2cm_pkg::item_t it;
  // output register and skid slot
  logic ov_q, sk_q;
  i2cm_pkg::result_t ob_q, sk_res_q;
  logic step;

  assign it = q_item_i;
  assign step = q_valid_i && !sk_q;
  assign q_pop_o = step;
  assign qp = (quarter_i == 16'd0) ? 16'd1 : quarter_i;
  assign div_inc = {1'b0, div_q} + 17'd1;
  assign left_dec = left_q - LENGTH_BITS'(1);
  assign len_in = LENGTH_BITS'(it.length);

  // next-state of one bus step
  always_comb begin
    phase_d = phase_q; stage_d = stage_q; div_d = div_q; shift_d = shift_q;
    dev_d = dev_q; reg_d = reg_q; bit_d = bit_q; pend_d = pend_q;
    left_d = left_q; op_d = op_q; scl_d = scl_q; sda_d = sda_q;
    res = '0;
    tick = 1'b0;
    if (phase_q != PH_IDLE && phase_q != PH_WAIT_BYTE) begin
      if (div_inc >= {1'b0, qp}) begin
        div_d = 16'd0; tick = 1'b1;
      end else begin
        div_d = div_inc[15:0];
      end
    end
    unique case (phase_q)
      PH_IDLE: begin
        if (it.kind == i2cm_pkg::KIND_START) begin
          op_d = it.op; dev_d = it.target_addr; reg_d = it.reg_addr; left_d = len_in;
          if (len_in == '0) begin
            res.done_res = 1'b1; res.status = i2cm_pkg::ST_ZERO_LEN;
          end else begin
            stage_d = SG_DEV;
            shift_d = (it.op == i2cm_pkg::OP_RD) ? (it.target_addr | 8'h01)
                                                 : (it.target_addr & 8'hFE);
            phase_d = PH_START_HI; scl_d = 1'b1; sda_d = 1'b1; div_d = '0;
          end
        end
      end
      PH_START_HI: if (tick) begin
        phase_d = PH_START_SDA; scl_d = 1'b1; sda_d = 1'b0;
      end
      PH_START_SDA: if (tick) begin
        phase_d = PH_START_LOW; scl_d = 1'b0; sda_d = 1'b0;
      end
      PH_START_LOW: if (tick) begin
        bit_d = '0; phase_d = PH_TX_SETUP; scl_d = 1'b0; sda_d = shift_q[7];
      end
      PH_TX_SETUP: if (tick) begin
        phase_d = PH_TX_HIGH; scl_d = 1'b1;
      end
      PH_TX_HIGH: if (tick) begin
        phase_d = PH_TX_LOW; scl_d = 1'b0;
      end
      PH_TX_LOW: if (tick) begin
        shift_d = {shift_q[6:0], 1'b0};
        if (bit_q == 3'd7) begin
          bit_d = '0; phase_d = PH_ACK_REL; sda_d = 1'b1;
        end else begin
          bit_d = bit_q + 3'd1; phase_d = PH_TX_SETUP; sda_d = shift_q[6];
        end
      end
      PH_ACK_REL: if (tick) begin
        phase_d = PH_ACK_HIGH; scl_d = 1'b1; sda_d = 1'b1;
      end
      PH_ACK_HIGH: if (tick) begin
        scl_d = 1'b0;
        if (it.sda_in) begin
          pend_d = (stage_q == SG_DEV) ? i2cm_pkg::ST_DEV_NAK :
                   (stage_q == SG_REG) ? i2cm_pkg::ST_REG_NAK : i2cm_pkg::ST_DATA_NAK;
          phase_d = PH_STOP_LOW; sda_d = 1'b0;
        end else if (stage_q == SG_DEV) begin
          if (op_q == i2cm_pkg::OP_WR) begin
            stage_d = SG_DATA_TX; phase_d = PH_WAIT_BYTE;
          end else if (op_q == i2cm_pkg::OP_RD) begin
            stage_d = SG_DATA_RX; bit_d = '0; phase_d = PH_RX_LOW; sda_d = 1'b1;
          end else begin
            stage_d = SG_REG; shift_d = reg_q; bit_d = '0;
            phase_d = PH_TX_SETUP; sda_d = reg_q[7];
          end
        end else if (stage_q == SG_REG) begin
          if (op_q == i2cm_pkg::OP_REG_WR) begin
            stage_d = SG_DATA_TX; phase_d = PH_WAIT_BYTE;
          end else begin
            stage_d = SG_REREAD; shift_d = dev_q | 8'h01;
            phase_d = PH_START_HI; scl_d = 1'b1; sda_d = 1'b1;
          end
        end else if (stage_q == SG_DATA_TX) begin
          left_d = left_dec;
          if (left_dec == '0) begin
            pend_d = i2cm_pkg::ST_OK; phase_d = PH_STOP_LOW; sda_d = 1'b0;
          end else begin
            phase_d = PH_WAIT_BYTE;
          end
        end else begin
          stage_d = SG_DATA_RX; bit_d = '0; phase_d = PH_RX_LOW; sda_d = 1'b1;
        end
      end
      PH_WAIT_BYTE: if (it.kind == i2cm_pkg::KIND_BYTE) begin
        shift_d = it.write_byte; bit_d = '0; div_d = '0;
        phase_d = PH_TX_SETUP; scl_d = 1'b0; sda_d = it.write_byte[7];
      end
      PH_RX_LOW: if (tick) begin
        phase_d = PH_RX_HIGH; scl_d = 1'b1; sda_d = 1'b1;
      end
      PH_RX_HIGH: if (tick) begin
        shift_d = {shift_q[6:0], it.sda_in};
        scl_d = 1'b0;
        if (bit_q == 3'd7) begin
          bit_d = '0;
          res.read_valid = 1'b1;
          res.read_byte = {shift_q[6:0], it.sda_in};
          res.read_last = (left_dec == '0);
          left_d = left_dec;
          phase_d = PH_M_LOW; sda_d = (left_dec == '0);
        end else begin
          bit_d = bit_q + 3'd1; phase_d = PH_RX_LOW; sda_d = 1'b1;
        end
      end
      PH_M_LOW: if (tick) begin
        phase_d = PH_M_HIGH; scl_d = 1'b1;
      end
      PH_M_HIGH: if (tick) begin
        scl_d = 1'b0;
        if (left_q == '0) begin
          pend_d = i2cm_pkg::ST_OK; phase_d = PH_STOP_LOW; sda_d = 1'b0;
        end else begin
          phase_d = PH_RX_LOW; sda_d = 1'b1;
        end
      end
      PH_STOP_LOW: if (tick) begin
        phase_d = PH_STOP_HIGH; scl_d = 1'b1; sda_d = 1'b0;
      end
      PH_STOP_HIGH: if (tick) begin
        phase_d = PH_STOP_REL; scl_d = 1'b1; sda_d = 1'b1;
      end
      PH_STOP_REL: if (tick) begin
        res.done_res = 1'b1; res.status = pend_q;
        phase_d = PH_IDLE; scl_d = 1'b1; sda_d = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE; scl_d = 1'b1; sda_d = 1'b1; div_d = '0;
      end
    endcase
    res.scl_out = scl_d;
    res.sda_out = sda_d;
    res.busy_res = (phase_d != PH_IDLE);
    res.byte_request = (phase_d == PH_WAIT_BYTE);
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; stage_q <= SG_DEV; div_q <= '0; shift_q <= '0;
      dev_q <= '0; reg_q <= '0; bit_q <= '0; pend_q <= '0; left_q <= '0;
      op_q <= '0; scl_q <= 1'b1; sda_q <= 1'b1;
    end else if (step) begin
      phase_q <= phase_d; stage_q <= stage_d; div_q <= div_d; shift_q <= shift_d;
      dev_q <= dev_d; reg_q <= reg_d; bit_q <= bit_d; pend_q <= pend_d;
      left_q <= left_d; op_q <= op_d; scl_q <= scl_d; sda_q <= sda_d;
    end
  end

  // output register with skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sk_q <= 1'b0;
    end else begin
      if (!ov_q || !out_stall_i) begin
        if (sk_q) begin
          ov_q <= 1'b1; sk_q <= step;
        end else begin
          ov_q <= step;
        end
      end else if (step) begin
        sk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || !out_stall_i) begin
      if (sk_q) begin
        ob_q <= sk_res_q;
        if (step) sk_res_q <= res;
      end else begin
        ob_q <= res;
      end
    end else if (step) begin
      sk_res_q <= res;
    end
  end

  assign out_valid_o = ov_q;
  assign out_res_o = ob_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sk_q |-> ov_q)
    else $error("skid slot full while output empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT_BYTE) |-> (div_q == $past(div_q) || $past(phase_q) != PH_WAIT_BYTE))
    else $error("divider ran while waiting for byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (scl_q && sda_q))
    else $error("bus not released when idle");
endmodule
`default_nettype wire

// ===== sv/i2c_master_transaction_engine_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine_unit
// Bit-banged i2c master running write, read, register write and register read.
// ----------------------------------------------------------------------------
// Usage: each input transfer (kind, op, addresses, length, write byte and the
// sampled sda level) advances the bus engine by one system step and yields
// exactly one result transfer with the line drive, busy, byte request, read
// data and done/status. Items enter a two-entry queue, the sequencer takes
// one per clock while its skid slot is empty and registers its result; one item
// per cycle is sustained unless the output stalls. Bus timing counts steps: each
// phase but idle and byte wait lasts quarter_i items. The quarter period register
// is written through cfg_we_i/cfg_data_i; the user must write it only while idle,
// the block does not enforce it. Reset leaves it at 125, the bus released and the
// engine idle. When the output is stalled the result is held; a skid slot and the
// queue absorb items in flight, then in_stall_o rises. Nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module i2c_master_transaction_engine_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [15:0] cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [1:0]  kind_i,
  input  wire [1:0]  op_i,
  input  wire [7:0]  target_addr_i,
  input  wire [7:0]  reg_addr_i,
  input  wire [15:0] length_i,
  input  wire [7:0]  write_byte_i,
  input  wire        sda_in_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       byte_request_o,
  output logic       read_valid_o,
  output logic [7:0] read_byte_o,
  output logic       read_last_o,
  output logic       done_res_o,
  output logic [2:0] status_o
);
  logic [15:0] quarter_q;
  i2cm_pkg::item_t in_item, q_item;
  i2cm_pkg::result_t res;
  logic q_valid, q_pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quarter_q <= i2cm_pkg::QUARTER_RESET;
    else if (cfg_we_i) quarter_q <= cfg_data_i;
  end

  assign in_item = '{kind: kind_i, op: op_i, target_addr: target_addr_i,
                     reg_addr: reg_addr_i, length: length_i,
                     write_byte: write_byte_i, sda_in: sda_in_i};

  i2cm_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  i2cm_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .quarter_i(quarter_q), .q_valid_i(q_valid),
    .q_pop_o(q_pop), .q_item_i(q_item), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .out_res_o(res)
  );

  assign scl_out_o = res.scl_out;
  assign sda_out_o = res.sda_out;
  assign busy_res_o = res.busy_res;
  assign byte_request_o = res.byte_request;
  assign read_valid_o = res.read_valid;
  assign read_byte_o = res.read_byte;
  assign read_last_o = res.read_last;
  assign done_res_o = res.done_res;
  assign status_o = res.status;
endmodule
`default_nettype wire
